### hw/rtl/dcr_pkg.sv
// Shared types and constants for the DC offset removal and derotation block.
// No dependencies; imported by every module of the block.
`default_nettype none

package dcr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int INDEX_W     = 8;
   localparam int THRESH_W    = 15;
   localparam int TAIL_W      = 4;
   localparam int CSR_DATA_W  = 15;
   localparam int CSR_ADDR_W  = 1;
   // wide enough for position + 1 and for tail + window length
   localparam int CMP_W       = INDEX_W + 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd32767;
   localparam logic [TAIL_W-1:0]   TAIL_RESET   = 4'd3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_OFFSET_THRESHOLD = 1'b0,
      CSR_TAIL_COUNT       = 1'b1
   } csr_reg_type;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_READ = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                       req_type;
      logic signed [SAMPLE_W-1:0] sample_i;
      logic signed [SAMPLE_W-1:0] sample_q;
      logic [INDEX_W-1:0]         read_index;
   } req_beat_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_i;
      logic signed [SAMPLE_W-1:0] out_q;
      logic [INDEX_W-1:0]         out_index;
      logic                       offset_ready;
      logic                       last;
   } rsp_beat_type;

   // classified command passed from front to back
   typedef struct packed {
      logic                       is_read;
      logic signed [SAMPLE_W-1:0] sample_i;
      logic signed [SAMPLE_W-1:0] sample_q;
      logic [INDEX_W-1:0]         index;
      logic                       in_window;
      logic                       burst_start;
      logic                       window_end;
      logic                       derot;
      logic [1:0]                 phase;
      logic                       last;
   } cmd_type;

endpackage

`default_nettype wire

### hw/rtl/dc_offset_removal_derotator.sv
// Top level of the DC offset removal and derotation block: CSRs, front end,
// command queue and back end. Depends on dcr_pkg, dcr_front, dcr_queue, dcr_back.
//
//   channel | dir | handshake          | beat
//   req     | in  | req_valid/stall    | load sample, or read by index
//   rsp     | out | rsp_valid/stall    | one beat per read, none per load
//   csr     | in  | csr_we             | offset_threshold (0), tail_count (1)
//
// One request beat per cycle is taken while the queue has room. A load
// writes the buffer and accumulates when popped from the queue; the estimate
// is registered from the sums after the closing load. A read's response
// passes through the buffer read register, then derotation into the response
// register. Sustained rate is one beat per cycle unless the response stalls,
// set by the single buffer port. Reset clears position, sums and estimate.
// A stalled response holds the read behind it; the queue absorbs four beats.
`default_nettype none

module dc_offset_removal_derotator #(
   parameter int BURST_LEN      = 156,
   parameter int OFFSET_SAMPLES = 64,
   parameter int OFFSET_SHIFT   = 6
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire dcr_pkg::req_beat_type           req_data,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      dcr_pkg::rsp_beat_type           rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [dcr_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  wire logic [dcr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dcr_pkg::*;

   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [TAIL_W-1:0]   tail_ff, tail_in;
   logic                q_full, q_empty, q_push, q_pop;
   cmd_type             push_cmd, head_cmd;

   always_comb begin
      thresh_in = thresh_ff;
      tail_in   = tail_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            CSR_OFFSET_THRESHOLD: thresh_in = csr_wdata[THRESH_W-1:0];
            CSR_TAIL_COUNT:       tail_in   = csr_wdata[TAIL_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         tail_ff   <= TAIL_RESET;
      end else begin
         thresh_ff <= thresh_in;
         tail_ff   <= tail_in;
      end
   end

   dcr_front #(
      .BURST_LEN      (BURST_LEN),
      .OFFSET_SAMPLES (OFFSET_SAMPLES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .tail_count (tail_ff),
      .queue_full (q_full),
      .push       (q_push),
      .push_cmd   (push_cmd)
   );

   dcr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head_cmd)
   );

   dcr_back #(
      .BURST_LEN      (BURST_LEN),
      .OFFSET_SAMPLES (OFFSET_SAMPLES),
      .OFFSET_SHIFT   (OFFSET_SHIFT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (q_empty),
      .head             (head_cmd),
      .pop              (q_pop),
      .offset_threshold (thresh_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

`default_nettype wire

### hw/rtl/dcr_front.sv
// Front end: accepts request beats, tracks the load position and classifies
// each beat into a command. Depends on dcr_pkg.
`default_nettype none

module dcr_front #(
   parameter int BURST_LEN      = 156,
   parameter int OFFSET_SAMPLES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire dcr_pkg::req_beat_type         req_data,
   input  wire logic [dcr_pkg::TAIL_W-1:0]    tail_count,
   input  wire logic                          queue_full,
   output      logic                          push,
   output      dcr_pkg::cmd_type              push_cmd
);
   import dcr_pkg::*;

   localparam logic [CMP_W-1:0] BURST_LEN_C = CMP_W'(BURST_LEN);
   localparam logic [CMP_W-1:0] LAST_POS_C  = CMP_W'(BURST_LEN - 1);
   localparam logic [CMP_W-1:0] WINDOW_C    = CMP_W'(OFFSET_SAMPLES);

   logic [INDEX_W-1:0] load_pos_ff, load_pos_in;
   logic [CMP_W-1:0]   pos_x, pos_next, wend, tail_x, idx_x, rel_x, start_x;
   logic [INDEX_W-1:0] idx, rel;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      tail_x   = CMP_W'(tail_count);
      pos_x    = CMP_W'(load_pos_ff);
      pos_next = pos_x + 1'b1;
      wend     = tail_x + WINDOW_C;

      // out-of-range reads land on the final position
      if (CMP_W'(req_data.read_index) >= BURST_LEN_C) begin
         idx = LAST_POS_C[INDEX_W-1:0];
      end else begin
         idx = req_data.read_index;
      end
      idx_x   = CMP_W'(idx);
      rel     = idx - INDEX_W'(tail_count);
      rel_x   = CMP_W'({rel[INDEX_W-1:2], 2'b00});
      start_x = tail_x + rel_x;

      push_cmd.is_read     = (req_data.req_type == REQ_READ);
      push_cmd.sample_i    = req_data.sample_i;
      push_cmd.sample_q    = req_data.sample_q;
      push_cmd.in_window   = (pos_x >= tail_x) && (pos_x < wend);
      push_cmd.burst_start = (load_pos_ff == '0);
      push_cmd.window_end  = (pos_next == wend) || (pos_next == BURST_LEN_C);
      push_cmd.derot       = (idx_x >= tail_x) && ((start_x + CMP_W'(3)) < BURST_LEN_C);
      push_cmd.phase       = rel[1:0];
      push_cmd.last        = (idx_x == LAST_POS_C);
      push_cmd.index       = push_cmd.is_read ? idx : load_pos_ff;

      load_pos_in = load_pos_ff;
      if (push && !push_cmd.is_read) begin
         if (pos_next >= BURST_LEN_C) begin
            load_pos_in = '0;
         end else begin
            load_pos_in = pos_next[INDEX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
      end else begin
         load_pos_ff <= load_pos_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/dcr_queue.sv
// Short command queue between front and back ends.
// Depends on dcr_pkg for the command type and depth.
`default_nettype none

module dcr_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire dcr_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output      logic             full,
   output      logic             empty,
   output      dcr_pkg::cmd_type head
);
   import dcr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/dcr_back.sv
// Back end: burst buffer, offset accumulation and estimate, derotation and
// the response register. Depends on dcr_pkg.
`default_nettype none

module dcr_back #(
   parameter int BURST_LEN      = 156,
   parameter int OFFSET_SAMPLES = 64,
   parameter int OFFSET_SHIFT   = 6
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           empty,
   input  wire dcr_pkg::cmd_type               head,
   output      logic                           pop,
   input  wire logic [dcr_pkg::THRESH_W-1:0]   offset_threshold,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      dcr_pkg::rsp_beat_type          rsp_data
);
   import dcr_pkg::*;

   localparam int ADDR_W = $clog2(BURST_LEN);
   localparam int SUM_W  = SAMPLE_W + $clog2(OFFSET_SAMPLES) + 1;
   localparam int RND_W  = SUM_W + 1;
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam logic signed [RND_W-1:0] ROUND_C = RND_W'(1) <<< (OFFSET_SHIFT - 1);
   localparam logic signed [DIFF_W-1:0] SAT_MAX = DIFF_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [DIFF_W-1:0] SAT_MIN = -SAT_MAX - DIFF_W'(1);

   function automatic logic signed [SAMPLE_W-1:0] sat(input logic signed [DIFF_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      priority if (v > SAT_MAX) begin
         r = SAT_MAX[SAMPLE_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   logic signed [SAMPLE_W-1:0] mem_i [BURST_LEN];
   logic signed [SAMPLE_W-1:0] mem_q [BURST_LEN];

   logic signed [SUM_W-1:0]    sum_i_ff, sum_i_in, sum_q_ff, sum_q_in;
   logic signed [SAMPLE_W-1:0] dc_i_ff, dc_i_in, dc_q_ff, dc_q_in;
   logic                       valid_ff, valid_in, form_ff, form_in;

   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] rd_i_ff, rd_q_ff;
   logic [INDEX_W-1:0]         s1_index_ff;
   logic                       s1_derot_ff, s1_last_ff;
   logic [1:0]                 s1_phase_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_beat_type               rsp_ff, rsp_in;

   logic                       out_free, load_pop, read_pop, valid_now;
   logic signed [SUM_W-1:0]    add_i, add_q, base_i, base_q;
   logic signed [RND_W-1:0]    rnd_i, rnd_q, thr_pos, thr_neg;
   logic signed [DIFF_W-1:0]   ri, rq, di, dq;
   logic signed [SAMPLE_W-1:0] oi, oq;

   function automatic logic signed [SAMPLE_W-1:0] clamp(
      input logic signed [RND_W-1:0] v,
      input logic signed [RND_W-1:0] hi,
      input logic signed [RND_W-1:0] lo
   );
      logic signed [RND_W-1:0] r;
      priority if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r[SAMPLE_W-1:0];
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // a stalled read in stage 1 blocks everything behind it, keeping order
   assign pop       = !empty && (!s1_valid_ff || out_free);
   assign load_pop  = pop && !head.is_read;
   assign read_pop  = pop && head.is_read;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // accumulation and estimate
   always_comb begin
      add_i  = head.in_window ? SUM_W'(head.sample_i) : '0;
      add_q  = head.in_window ? SUM_W'(head.sample_q) : '0;
      base_i = head.burst_start ? '0 : sum_i_ff;
      base_q = head.burst_start ? '0 : sum_q_ff;
      valid_now = head.burst_start ? 1'b0 : valid_ff;

      sum_i_in = sum_i_ff;
      sum_q_in = sum_q_ff;
      valid_in = valid_ff;
      form_in  = 1'b0;
      if (load_pop) begin
         sum_i_in = base_i + add_i;
         sum_q_in = base_q + add_q;
         valid_in = valid_now || head.window_end;
         form_in  = head.window_end && !valid_now;
      end

      // estimate formed the cycle after the closing load
      rnd_i   = (RND_W'(sum_i_ff) + ROUND_C) >>> OFFSET_SHIFT;
      rnd_q   = (RND_W'(sum_q_ff) + ROUND_C) >>> OFFSET_SHIFT;
      thr_pos = RND_W'({1'b0, offset_threshold});
      thr_neg = -thr_pos;
      dc_i_in = dc_i_ff;
      dc_q_in = dc_q_ff;
      if (form_ff) begin
         dc_i_in = clamp(rnd_i, thr_pos, thr_neg);
         dc_q_in = clamp(rnd_q, thr_pos, thr_neg);
      end
   end

   // derotation of the sample held in stage 1
   always_comb begin
      ri = DIFF_W'(rd_i_ff);
      rq = DIFF_W'(rd_q_ff);
      di = DIFF_W'(dc_i_ff);
      dq = DIFF_W'(dc_q_ff);
      oi = rd_i_ff;
      oq = rd_q_ff;
      if (s1_derot_ff) begin
         unique case (s1_phase_ff)
            2'd0: begin
               oi = sat(rq - dq);
               oq = sat(di - ri);
            end
            2'd1: begin
               oi = sat(di - ri);
               oq = sat(dq - rq);
            end
            2'd2: begin
               oi = sat(dq - rq);
               oq = sat(ri - di);
            end
            default: begin
               oi = sat(ri - di);
               oq = sat(rq - dq);
            end
         endcase
      end

      rsp_in.out_i        = oi;
      rsp_in.out_q        = oq;
      rsp_in.out_index    = s1_index_ff;
      rsp_in.offset_ready = valid_ff;
      rsp_in.last         = s1_last_ff;

      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (read_pop) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_i_ff     <= '0;
         sum_q_ff     <= '0;
         dc_i_ff      <= '0;
         dc_q_ff      <= '0;
         valid_ff     <= 1'b0;
         form_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_i_ff     <= sum_i_in;
         sum_q_ff     <= sum_q_in;
         dc_i_ff      <= dc_i_in;
         dc_q_ff      <= dc_q_in;
         valid_ff     <= valid_in;
         form_ff      <= form_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
      if (read_pop) begin
         s1_index_ff <= head.index;
         s1_derot_ff <= head.derot;
         s1_phase_ff <= head.phase;
         s1_last_ff  <= head.last;
      end
   end

   // burst buffer: one write or one registered read per cycle, for each popped command
   always_ff @(posedge clock) begin
      if (load_pop) begin
         mem_i[head.index[ADDR_W-1:0]] <= head.sample_i;
         mem_q[head.index[ADDR_W-1:0]] <= head.sample_q;
      end
      if (read_pop) begin
         rd_i_ff <= mem_i[head.index[ADDR_W-1:0]];
         rd_q_ff <= mem_q[head.index[ADDR_W-1:0]];
      end
   end

endmodule

`default_nettype wire
